// File: src/bfic_pkg.sv
// Shared constants, codes and controller/datapath interface types for the Brainfuck core.
package bfic_pkg;

  localparam int TAPE_DEPTH = 1024;
  localparam int PROG_DEPTH = 1024;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int TCNT_W  = TAPE_AW + 1;
  localparam int PLEN_W  = PROG_AW + 1;
  localparam int CFG_W   = 11;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_STEP  = 2'd1;
  localparam cmd_t CMD_RESET = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_END     = 2'd1;
  localparam status_t ST_UNKNOWN = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LATCH,
    DP_LOAD,
    DP_FETCH,
    DP_INC,
    DP_DEC,
    DP_LEFT,
    DP_RIGHT,
    DP_SKIP,
    DP_EMIT,
    DP_FS_START,
    DP_FS_RD,
    DP_FS_CHK,
    DP_BS_START,
    DP_BS_RD,
    DP_BS_CHK,
    DP_CLR_START,
    DP_CLR_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    out_load;
    status_t out_status;
    logic    out_emit;
  } bfic_cmd_t;

  typedef struct packed {
    logic [7:0] op_byte;
    logic       cell_zero;
    logic       at_end;
    logic       full;
    logic       depth_zero;
    logic       ip_zero;
    logic       clr_last;
    logic       out_free;
  } bfic_stat_t;

endpackage

// File: src/bfic_ctrl.sv
// Controller state machine that sequences loads, steps, bracket scans and tape clearing.
module bfic_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  bfic_pkg::cmd_t       s_tuser,
  input  bfic_pkg::bfic_stat_t st,
  output bfic_pkg::bfic_cmd_t  cmd
);
  import bfic_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_FS_RD,
    S_FS_CHK,
    S_BS_RD,
    S_BS_CHK,
    S_DONE
  } state_t;

  state_t  state, state_next;
  status_t done_status, done_status_next;
  logic    clr_reply, clr_reply_next;

  logic    fin;
  dp_op_t  fin_op;
  status_t fin_status;
  logic    fin_emit;

  always_comb begin
    state_next       = state;
    done_status_next = done_status;
    clr_reply_next   = clr_reply;
    cmd              = '{op: DP_NONE, out_load: 1'b0, out_status: ST_OK, out_emit: 1'b0};
    fin              = 1'b0;
    fin_op           = DP_NONE;
    fin_status       = ST_OK;
    fin_emit         = 1'b0;
    s_tready         = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.op = DP_CLR_STEP;
        if (st.clr_last) begin
          if (clr_reply) begin
            done_status_next = ST_OK;
            state_next       = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            CMD_LOAD: begin
              cmd.op     = DP_LATCH;
              state_next = S_LOAD;
            end
            CMD_STEP: begin
              cmd.op     = DP_FETCH;
              state_next = S_EXEC;
            end
            CMD_RESET: begin
              cmd.op         = DP_CLR_START;
              clr_reply_next = 1'b1;
              state_next     = S_CLEAR;
            end
            default: begin
              done_status_next = ST_OK;
              state_next       = S_DONE;
            end
          endcase
        end
      end
      S_LOAD: begin
        fin        = 1'b1;
        fin_op     = st.full ? DP_NONE : DP_LOAD;
        fin_status = st.full ? ST_FULL : ST_OK;
      end
      S_EXEC: begin
        fin = 1'b1;
        if (st.at_end) begin
          fin_status = ST_END;
        end else begin
          unique case (st.op_byte)
            CH_PLUS:  fin_op = DP_INC;
            CH_MINUS: fin_op = DP_DEC;
            CH_LEFT:  fin_op = DP_LEFT;
            CH_RIGHT: fin_op = DP_RIGHT;
            CH_DOT: begin
              fin_op   = DP_EMIT;
              fin_emit = 1'b1;
            end
            CH_OPEN: begin
              if (st.cell_zero) begin
                fin        = 1'b0;
                cmd.op     = DP_FS_START;
                state_next = S_FS_RD;
              end else begin
                fin_op = DP_SKIP;
              end
            end
            CH_CLOSE: begin
              if (!st.cell_zero) begin
                fin        = 1'b0;
                cmd.op     = DP_BS_START;
                state_next = S_BS_RD;
              end else begin
                fin_op = DP_SKIP;
              end
            end
            default: begin
              fin_op     = DP_SKIP;
              fin_status = ST_UNKNOWN;
            end
          endcase
        end
      end
      S_FS_RD: begin
        if (st.depth_zero || st.at_end) begin
          fin = 1'b1;
        end else begin
          cmd.op     = DP_FS_RD;
          state_next = S_FS_CHK;
        end
      end
      S_FS_CHK: begin
        cmd.op     = DP_FS_CHK;
        state_next = S_FS_RD;
      end
      S_BS_RD: begin
        if (st.depth_zero || st.ip_zero) begin
          fin = 1'b1;
        end else begin
          cmd.op     = DP_BS_RD;
          state_next = S_BS_CHK;
        end
      end
      S_BS_CHK: begin
        cmd.op     = DP_BS_CHK;
        state_next = S_BS_RD;
      end
      S_DONE: begin
        fin        = 1'b1;
        fin_status = done_status;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin && st.out_free) begin
      cmd.op         = fin_op;
      cmd.out_load   = 1'b1;
      cmd.out_status = fin_status;
      cmd.out_emit   = fin_emit;
      clr_reply_next = 1'b0;
      state_next     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      done_status <= ST_OK;
      clr_reply   <= 1'b0;
    end else begin
      state       <= state_next;
      done_status <= done_status_next;
      clr_reply   <= clr_reply_next;
    end
  end

endmodule

// File: src/bfic_dp.sv
// Datapath with program store, tape memory, pointers, scan depth counter and result register.
module bfic_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  bfic_pkg::bfic_cmd_t       cmd,
  output bfic_pkg::bfic_stat_t      st,
  input  logic [7:0]                s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,
  output logic [2:0]                m_tuser,
  input  logic                      cfg_wen,
  input  logic [bfic_pkg::CFG_W-1:0] cfg_wdata
);
  import bfic_pkg::*;

  logic [7:0]         prog_mem [PROG_DEPTH];
  logic [7:0]         tape_mem [TAPE_DEPTH];

  logic [PLEN_W-1:0]  plen;
  logic [PLEN_W-1:0]  ip;
  logic [TAPE_AW-1:0] cp;
  logic [PLEN_W-1:0]  depth;
  logic [TAPE_AW-1:0] clr_cnt;
  logic [CFG_W-1:0]   tape_cells;

  logic [7:0]         prog_rdata;
  logic [7:0]         tape_rdata;
  logic [7:0]         char_reg;
  status_t            out_status;
  logic               out_emit;
  logic [7:0]         out_byte;

  logic [TCNT_W-1:0]  cells;
  logic [TCNT_W-1:0]  cp_inc;
  logic [TAPE_AW-1:0] cp_left;
  logic [TAPE_AW-1:0] cp_right;
  logic [PLEN_W-1:0]  ip_dec;

  logic               prog_re;
  logic [PROG_AW-1:0] prog_raddr;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [7:0]         tape_wdata;

  always_comb begin
    if (tape_cells == '0) begin
      cells = TCNT_W'(1);
    end else if (32'(tape_cells) > TAPE_DEPTH) begin
      cells = TCNT_W'(TAPE_DEPTH);
    end else begin
      cells = TCNT_W'(tape_cells);
    end
    cp_inc   = {1'b0, cp} + TCNT_W'(1);
    cp_right = (cp_inc >= cells) ? '0 : cp_inc[TAPE_AW-1:0];
    cp_left  = (cp == '0) ? TAPE_AW'(cells - TCNT_W'(1)) : cp - TAPE_AW'(1);
    ip_dec   = ip - PLEN_W'(1);
  end

  always_comb begin
    prog_re    = (cmd.op == DP_FETCH) || (cmd.op == DP_FS_RD) || (cmd.op == DP_BS_RD);
    prog_raddr = (cmd.op == DP_BS_RD) ? ip_dec[PROG_AW-1:0] : ip[PROG_AW-1:0];
    tape_we    = 1'b0;
    tape_waddr = cp;
    tape_wdata = tape_rdata;
    case (cmd.op)
      DP_INC: begin
        tape_we    = 1'b1;
        tape_wdata = tape_rdata + 8'd1;
      end
      DP_DEC: begin
        tape_we    = 1'b1;
        tape_wdata = tape_rdata - 8'd1;
      end
      DP_CLR_STEP: begin
        tape_we    = 1'b1;
        tape_waddr = clr_cnt;
        tape_wdata = 8'd0;
      end
      default: begin
        tape_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (prog_re) begin
      prog_rdata <= prog_mem[prog_raddr];
    end
    if (cmd.op == DP_LOAD) begin
      prog_mem[plen[PROG_AW-1:0]] <= char_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_FETCH) begin
      tape_rdata <= tape_mem[cp];
    end
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      char_reg <= s_tdata;
    end
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_emit   <= cmd.out_emit;
      out_byte   <= cmd.out_emit ? tape_rdata : 8'd0;
    end
    case (cmd.op)
      DP_FS_START, DP_BS_START: depth <= PLEN_W'(1);
      DP_FS_CHK: begin
        if (prog_rdata == CH_OPEN) begin
          depth <= depth + PLEN_W'(1);
        end else if (prog_rdata == CH_CLOSE) begin
          depth <= depth - PLEN_W'(1);
        end
      end
      DP_BS_CHK: begin
        if (prog_rdata == CH_CLOSE) begin
          depth <= depth + PLEN_W'(1);
        end else if (prog_rdata == CH_OPEN) begin
          depth <= depth - PLEN_W'(1);
        end
      end
      default: begin
        depth <= depth;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen       <= '0;
      ip         <= '0;
      cp         <= '0;
      clr_cnt    <= '0;
      m_tvalid   <= 1'b0;
      tape_cells <= CFG_W'(TAPE_DEPTH);
    end else begin
      if (cfg_wen) begin
        tape_cells <= cfg_wdata;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        DP_LOAD: plen <= plen + PLEN_W'(1);
        DP_INC, DP_DEC, DP_SKIP, DP_EMIT, DP_FS_START, DP_FS_CHK: ip <= ip + PLEN_W'(1);
        DP_LEFT: begin
          cp <= cp_left;
          ip <= ip + PLEN_W'(1);
        end
        DP_RIGHT: begin
          cp <= cp_right;
          ip <= ip + PLEN_W'(1);
        end
        DP_BS_CHK: ip <= ip_dec;
        DP_CLR_START: begin
          plen    <= '0;
          ip      <= '0;
          cp      <= '0;
          clr_cnt <= '0;
        end
        DP_CLR_STEP: clr_cnt <= clr_cnt + TAPE_AW'(1);
        default: begin
          ip <= ip;
        end
      endcase
    end
  end

  assign st.op_byte    = prog_rdata;
  assign st.cell_zero  = (tape_rdata == 8'd0);
  assign st.at_end     = (ip >= plen);
  assign st.full       = (plen == PLEN_W'(PROG_DEPTH));
  assign st.depth_zero = (depth == '0);
  assign st.ip_zero    = (ip == '0);
  assign st.clr_last   = (clr_cnt == TAPE_AW'(TAPE_DEPTH - 1));
  assign st.out_free   = !m_tvalid || m_tready;

  assign m_tdata = out_byte;
  assign m_tuser = {out_emit, out_status};

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while a transaction is pending");

  a_ip_in_program: assert property (@(posedge clk) disable iff (rst)
    ip <= plen)
    else $error("instruction pointer beyond program length");

  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_LOAD |-> plen < PLEN_W'(PROG_DEPTH))
    else $error("program write with store full");

  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && cmd.out_emit |=> m_tvalid && out_status == ST_OK && out_byte == $past(tape_rdata))
    else $error("emitted byte does not match fetched cell");

endmodule

// File: src/brainfuck_interpreter_core.sv
// Top level of the Brainfuck interpreter core: controller and datapath.
//
// The s_ channel takes one command per transaction: s_tuser selects load
// (append s_tdata as a program byte), step (execute one instruction) or
// reset (clear tape, pointers and program). Every command returns exactly
// one transaction on the m_ channel with a status in m_tuser[1:0], the
// output flag of a dot instruction in m_tuser[2] and, for a dot, the cell
// value in m_tdata. The user must write the tape_cells register through
// cfg_wen/cfg_wdata only while the core is idle; the core does not enforce it.
// A load, an unused command and any step other than a bracket scan
// pass through their own state (S_LOAD, S_DONE or S_EXEC) before their
// result is loaded into the result register. A bracket scan reads the
// program store one byte per pass through its read and check states
// (S_FS_RD/S_FS_CHK or S_BS_RD/S_BS_CHK). A reset command sweeps the tape
// memory one cell a cycle and then returns its result.
// After rst the same sweep runs with s_tready low.
// One command is in flight at a time. The result register lets the core
// accept the next command while a result waits; if the receiver stalls,
// that command waits at its final step until the register frees up.
module brainfuck_interpreter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // char_in
  input  logic [1:0]                 s_tuser,   // cmd
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // out_byte
  output logic [2:0]                 m_tuser,   // status[1:0], out_valid[2]
  input  logic                       cfg_wen,
  input  logic [bfic_pkg::CFG_W-1:0] cfg_wdata
);
  import bfic_pkg::*;

  bfic_cmd_t  cmd;
  bfic_stat_t st;

  bfic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .st       (st),
    .cmd      (cmd)
  );

  bfic_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// File: tb/sv/brainfuck_interpreter_core_tb.sv
// Self-checking testbench for brainfuck_interpreter_core: directed rows and random programs.
module brainfuck_interpreter_core_tb;
  import bfic_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    status_t    status;
    logic       emitted;
    logic [7:0] value;
  } step_result_t;

  typedef struct packed {
    cmd_t         cmd;
    logic [7:0]   ch;
    bit           typed;
    step_result_t res;
  } directed_row_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;
  logic [1:0]       s_tuser = CMD_LOAD;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic [2:0]       m_tuser;
  logic             cfg_wen = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [7:0] prog_mem [PROG_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];
  int prog_len;
  int instr_ptr;
  int cell_ptr;
  int tape_cells_cfg;

  step_result_t pending_results [$];
  int error_count = 0;
  int issued;
  int tx_idle_pct;
  int rx_idle_pct;
  int seq_no;
  bit hold_req;
  bit hold_ack;
  int hold_left;

  logic [CFG_W-1:0] cell_counts [9] = '{11'd1, 11'd2, 11'd0, 11'd3, 11'd2047,
                                        11'd1023, 11'd7, 11'd1024, 11'd5};

  directed_row_t directed_rows [25] = '{
    '{CMD_STEP,   8'h00,    1'b1, '{ST_END,     1'b0, 8'h00}},
    '{CMD_UNUSED, 8'hFF,    1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   8'h00,    1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b1, '{ST_UNKNOWN, 1'b0, 8'h00}},
    '{CMD_LOAD,   8'hFF,    1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'hFF,    1'b1, '{ST_UNKNOWN, 1'b0, 8'h00}},
    '{CMD_LOAD,   CH_MINUS, 1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_DOT,   1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_PLUS,  1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_LEFT,  1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_RIGHT, 1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_OPEN,  1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b1, '{ST_END,     1'b0, 8'h00}},
    '{CMD_RESET,  8'h5A,    1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_PLUS,  1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_LOAD,   CH_CLOSE, 1'b1, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}},
    '{CMD_STEP,   8'h00,    1'b0, '{ST_OK,      1'b0, 8'h00}}
  };

  brainfuck_interpreter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

  function automatic step_result_t bf_execute(cmd_t c, logic [7:0] ch);
    step_result_t r;
    int cells;
    int cp;
    int depth;
    int pos;
    logic [7:0] op;
    r = '{ST_OK, 1'b0, 8'h00};
    case (c)
      CMD_LOAD: begin
        if (prog_len >= PROG_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          prog_mem[prog_len] = ch;
          prog_len++;
        end
      end
      CMD_STEP: begin
        cells = (tape_cells_cfg == 0) ? 1 :
                (tape_cells_cfg > TAPE_DEPTH) ? TAPE_DEPTH : tape_cells_cfg;
        cp = cell_ptr % TAPE_DEPTH;
        if (instr_ptr >= prog_len) begin
          r.status = ST_END;
        end else begin
          op = prog_mem[instr_ptr];
          instr_ptr++;
          case (op)
            CH_PLUS:  tape_mem[cp] = tape_mem[cp] + 8'd1;
            CH_MINUS: tape_mem[cp] = tape_mem[cp] - 8'd1;
            CH_LEFT:  cell_ptr = (cp == 0) ? cells - 1 : cp - 1;
            CH_RIGHT: cell_ptr = (cp + 1 >= cells) ? 0 : cp + 1;
            CH_OPEN: begin
              if (tape_mem[cp] == 8'h00) begin
                depth = 1;
                while (depth > 0 && instr_ptr < prog_len) begin
                  if (prog_mem[instr_ptr] == CH_OPEN) depth++;
                  else if (prog_mem[instr_ptr] == CH_CLOSE) depth--;
                  instr_ptr++;
                end
              end
            end
            CH_CLOSE: begin
              if (tape_mem[cp] != 8'h00) begin
                pos = instr_ptr - 2;
                depth = 1;
                while (depth > 0 && pos >= 0) begin
                  if (prog_mem[pos] == CH_CLOSE) depth++;
                  else if (prog_mem[pos] == CH_OPEN) depth--;
                  pos--;
                end
                instr_ptr = pos + 1;
              end
            end
            CH_DOT: begin
              r.emitted = 1'b1;
              r.value = tape_mem[cp];
            end
            default: r.status = ST_UNKNOWN;
          endcase
        end
      end
      CMD_RESET: begin
        for (int i = 0; i < TAPE_DEPTH; i++) tape_mem[i] = 8'h00;
        prog_len = 0;
        instr_ptr = 0;
        cell_ptr = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    step_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, m_tuser", int'(m_tuser), -1);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[1:0] !== want.status)
          report_mismatch("status", int'(m_tuser[1:0]), int'(want.status));
        if (m_tuser[2] !== want.emitted)
          report_mismatch("out_valid", int'(m_tuser[2]), int'(want.emitted));
        if (m_tdata !== want.value)
          report_mismatch("out_byte", int'(m_tdata), int'(want.value));
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    hold_left = 0;
    hold_ack = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_cmd(cmd_t c, logic [7:0] d, bit typed, step_result_t typed_res);
    step_result_t predicted;
    predicted = bf_execute(c, d);
    if (typed) predicted = typed_res;
    pending_results = {pending_results, predicted};
    if (c != CMD_UNUSED) issued++;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tape_cells(logic [CFG_W-1:0] v);
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tape_cells_cfg = int'(v);
    @(posedge clk);
  endtask

  task automatic load_program(int len, bit balanced);
    int depth;
    int pick;
    logic [7:0] ch;
    depth = 0;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) ch = CH_PLUS;
      else if (pick < 28) ch = CH_MINUS;
      else if (pick < 38) ch = CH_LEFT;
      else if (pick < 48) ch = CH_RIGHT;
      else if (pick < 60) ch = CH_DOT;
      else if (pick < 72) ch = CH_OPEN;
      else if (pick < 84) ch = (depth > 0 || !balanced) ? CH_CLOSE : CH_MINUS;
      else if (pick < 92) ch = CH_PLUS;
      else ch = 8'($urandom_range(0, 255));
      if (ch == CH_OPEN) depth++;
      else if (ch == CH_CLOSE && depth > 0) depth--;
      send_cmd(CMD_LOAD, ch, 1'b0, '0);
    end
    if (balanced) begin
      for (int i = 0; i < depth; i++) send_cmd(CMD_LOAD, CH_CLOSE, 1'b0, '0);
    end
  endtask

  task automatic run_sequence(bit with_hold);
    int len;
    int nsteps;
    int pick;
    wait_idle();
    if (seq_no < 9) set_tape_cells(cell_counts[seq_no]);
    else if ($urandom_range(0, 2) == 0) set_tape_cells(cell_counts[$urandom_range(0, 8)]);
    else if ($urandom_range(0, 3) == 0) set_tape_cells(CFG_W'($urandom_range(0, 2047)));
    seq_no++;
    if ($urandom_range(0, 3) == 0) send_cmd(CMD_RESET, 8'($urandom_range(0, 255)), 1'b0, '0);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
    load_program(len, $urandom_range(0, 9) != 0);
    nsteps = 2 * len + $urandom_range(0, 20);
    for (int k = 0; k < nsteps; k++) begin
      if (with_hold && k == 3) hold_req = ~hold_req;
      pick = $urandom_range(0, 99);
      if (pick < 3) send_cmd(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0, '0);
      else if (pick < 6) send_cmd(CMD_LOAD, 8'($urandom_range(0, 255)), 1'b0, '0);
      else send_cmd(CMD_STEP, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  initial begin
    int target;
    issued = 0;
    seq_no = 0;
    hold_req = 1'b0;
    prog_len = 0;
    instr_ptr = 0;
    cell_ptr = 0;
    tape_cells_cfg = TAPE_DEPTH;
    for (int i = 0; i < TAPE_DEPTH; i++) tape_mem[i] = 8'h00;
    for (int i = 0; i < PROG_DEPTH; i++) prog_mem[i] = 8'h00;
    tx_idle_pct = 7;
    rx_idle_pct = 70;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].typed,
               directed_rows[i].res);
    end
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 70 : 0;
      rx_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 7 : 0;
      target = issued + 160;
      run_sequence(1'b1);
      while (issued < target) run_sequence(1'b0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: brainfuck_interpreter_core.f
src/bfic_pkg.sv
src/bfic_ctrl.sv
src/bfic_dp.sv
src/brainfuck_interpreter_core.sv
tb/sv/brainfuck_interpreter_core_tb.sv
